@@ src/nfcrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NFC response frame parser package
// Shared types and constants for the response frame parser.
// ----------------------------------------------------------------------------
package nfcrp_pkg;

    localparam int unsigned TICK_WIDTH = 16;

    localparam logic [7:0] REPLY_DIRECTION = 8'd213;
    localparam logic [7:0] PREAMBLE_START  = 8'h00;
    localparam logic [7:0] PREAMBLE_CODE   = 8'hFF;
    localparam logic [7:0] POSTAMBLE       = 8'h00;
    localparam logic [7:0] LENGTH_OVERHEAD = 8'd2;

    localparam logic [7:0]  CAPACITY_RESET = 8'd255;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

    // Configuration register indexes
    localparam logic [7:0] REG_BUFFER_CAPACITY = 8'd0;
    localparam logic [7:0] REG_TIMEOUT_TICKS   = 8'd1;

    typedef enum logic [1:0] {
        OP_ARM  = 2'd0,
        OP_BYTE = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_INVALID = 2'd2,
        ST_NOSPACE = 2'd3
    } status_t;

    typedef enum logic [10:0] {
        PH_IDLE = 11'b000_0000_0001,
        PH_PRE0 = 11'b000_0000_0010,
        PH_PRE1 = 11'b000_0000_0100,
        PH_PRE2 = 11'b000_0000_1000,
        PH_LEN  = 11'b000_0001_0000,
        PH_LCS  = 11'b000_0010_0000,
        PH_DIR  = 11'b000_0100_0000,
        PH_CODE = 11'b000_1000_0000,
        PH_DATA = 11'b001_0000_0000,
        PH_DCS  = 11'b010_0000_0000,
        PH_POST = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
        logic [7:0] command_code;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        status_t    status;
        logic [7:0] data_length;
        logic       last;
    } out_item_t;

endpackage
`default_nettype wire

@@ src/nfc_response_frame_parser_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Timing: a request lands in the input register at its accept edge; its result (if
//   any) loads the result register when the request advances, and drives m_valid.
// Throughput: one request per cycle while the result register is free or drains;
//   the single-pass frame state update is the only logic between the two registers.
// Reset: synchronous active-low aresetn clears both pipeline valids, the frame
//   state (idle, not armed) and loads capacity 255 and timeout 1000.
// ----------------------------------------------------------------------------
// NFC response frame parser
// Walks a reader's response frame one received byte at a time, forwards the
// payload bytes and closes each frame with a single status result.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser_top (
    input  wire                    aclk,
    input  wire                    aresetn,
    // request channel
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire nfcrp_pkg::in_item_t s_item,
    // result channel
    output logic                   m_valid,
    input  wire                    m_ready,
    output nfcrp_pkg::out_item_t   m_item,
    // configuration write channel
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [7:0]             cfg_index,
    input  wire  [15:0]            cfg_data
);

    localparam logic [nfcrp_pkg::TICK_WIDTH-1:0] TICK_MAX = '1;

    // Input register
    logic                  in_valid_reg;
    nfcrp_pkg::in_item_t   in_item_reg;

    // Result register
    logic                  out_valid_reg;
    nfcrp_pkg::out_item_t  out_item_reg;

    // Configuration
    logic [7:0]  capacity_reg;
    logic [15:0] timeout_reg;

    // Frame state
    nfcrp_pkg::phase_t               phase_reg, phase_next;
    logic [7:0]                      expected_reg, expected_next;
    logic [7:0]                      length_reg, length_next;
    logic [7:0]                      left_reg, left_next;
    logic [7:0]                      paylen_reg, paylen_next;
    logic [7:0]                      sum_reg, sum_next;
    logic [nfcrp_pkg::TICK_WIDTH-1:0] idle_reg, idle_next;

    logic                  res_valid;
    nfcrp_pkg::out_item_t  res_item;
    logic                  advance;

    logic [7:0]                       rx;
    logic [7:0]                       len_sum;
    logic [7:0]                       len_payload;
    logic [nfcrp_pkg::TICK_WIDTH-1:0] idle_inc;

    // Process the held request whenever the result register is free or drains now
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    assign rx          = in_item_reg.rx_byte;
    assign len_sum     = length_reg + rx;
    assign len_payload = length_reg - nfcrp_pkg::LENGTH_OVERHEAD;
    assign idle_inc    = (idle_reg == TICK_MAX) ? idle_reg : idle_reg + 1'b1;

    // Frame state update for one request
    always_comb begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        length_next   = length_reg;
        left_next     = left_reg;
        paylen_next   = paylen_reg;
        sum_next      = sum_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        res_item      = '0;

        if (in_item_reg.op == nfcrp_pkg::OP_ARM) begin
            // Arm (or re-arm): abandon any frame and wait for the preamble
            expected_next = in_item_reg.command_code + 8'd1;
            length_next   = '0;
            left_next     = '0;
            paylen_next   = '0;
            sum_next      = '0;
            idle_next     = '0;
            phase_next    = nfcrp_pkg::PH_PRE0;
        end else if (phase_reg != nfcrp_pkg::PH_IDLE) begin
            if (in_item_reg.op == nfcrp_pkg::OP_BYTE) begin
                idle_next = '0;
                unique case (phase_reg)
                    nfcrp_pkg::PH_PRE0: begin
                        if (rx != nfcrp_pkg::PREAMBLE_START) begin
                            res_valid = 1'b1;
                            res_item.status = nfcrp_pkg::ST_INVALID;
                        end else begin
                            phase_next = nfcrp_pkg::PH_PRE1;
                        end
                    end
                    nfcrp_pkg::PH_PRE1: begin
                        if (rx != nfcrp_pkg::PREAMBLE_START) begin
                            res_valid = 1'b1;
                            res_item.status = nfcrp_pkg::ST_INVALID;
                        end else begin
                            phase_next = nfcrp_pkg::PH_PRE2;
                        end
                    end
                    nfcrp_pkg::PH_PRE2: begin
                        if (rx != nfcrp_pkg::PREAMBLE_CODE) begin
                            res_valid = 1'b1;
                            res_item.status = nfcrp_pkg::ST_INVALID;
                        end else begin
                            phase_next = nfcrp_pkg::PH_LEN;
                        end
                    end
                    nfcrp_pkg::PH_LEN: begin
                        length_next = rx;
                        phase_next  = nfcrp_pkg::PH_LCS;
                    end
                    nfcrp_pkg::PH_LCS: begin
                        // Length and its checksum must sum to zero
                        if (len_sum != 8'd0) begin
                            res_valid = 1'b1;
                            res_item.status = nfcrp_pkg::ST_INVALID;
                        end else begin
                            paylen_next = len_payload;
                            if (len_payload > capacity_reg) begin
                                res_valid = 1'b1;
                                res_item.status = nfcrp_pkg::ST_NOSPACE;
                            end else begin
                                left_next  = len_payload;
                                phase_next = nfcrp_pkg::PH_DIR;
                            end
                        end
                    end
                    nfcrp_pkg::PH_DIR: begin
                        if (rx != nfcrp_pkg::REPLY_DIRECTION) begin
                            res_valid = 1'b1;
                            res_item.status = nfcrp_pkg::ST_INVALID;
                        end else begin
                            sum_next   = rx;
                            phase_next = nfcrp_pkg::PH_CODE;
                        end
                    end
                    nfcrp_pkg::PH_CODE: begin
                        if (rx != expected_reg) begin
                            res_valid = 1'b1;
                            res_item.status = nfcrp_pkg::ST_INVALID;
                        end else begin
                            sum_next   = sum_reg + rx;
                            phase_next = (left_reg == 8'd0) ? nfcrp_pkg::PH_DCS
                                                            : nfcrp_pkg::PH_DATA;
                        end
                    end
                    nfcrp_pkg::PH_DATA: begin
                        // Forward the payload byte as it arrives
                        sum_next  = sum_reg + rx;
                        left_next = left_reg - 8'd1;
                        if (left_reg == 8'd1) begin
                            phase_next = nfcrp_pkg::PH_DCS;
                        end
                        res_valid          = 1'b1;
                        res_item.data_byte = rx;
                    end
                    nfcrp_pkg::PH_DCS: begin
                        if (sum_reg + rx != 8'd0) begin
                            res_valid = 1'b1;
                            res_item.status = nfcrp_pkg::ST_INVALID;
                        end else begin
                            phase_next = nfcrp_pkg::PH_POST;
                        end
                    end
                    nfcrp_pkg::PH_POST: begin
                        res_valid = 1'b1;
                        if (rx != nfcrp_pkg::POSTAMBLE) begin
                            res_item.status = nfcrp_pkg::ST_INVALID;
                        end else begin
                            res_item.status      = nfcrp_pkg::ST_OK;
                            res_item.data_length = paylen_reg;
                        end
                    end
                    default: begin
                        phase_next = nfcrp_pkg::PH_IDLE;
                    end
                endcase
            end else if (in_item_reg.op == nfcrp_pkg::OP_TICK) begin
                // Count idle time; a zero limit never expires
                idle_next = idle_inc;
                if (timeout_reg != 16'd0 && idle_inc >= timeout_reg) begin
                    res_valid = 1'b1;
                    res_item.status = nfcrp_pkg::ST_TIMEOUT;
                end
            end

            // Any status result closes the frame
            if (res_valid && in_item_reg.op != nfcrp_pkg::OP_BYTE) begin
                res_item.kind = 1'b1;
                res_item.last = 1'b1;
                phase_next    = nfcrp_pkg::PH_IDLE;
                idle_next     = '0;
            end else if (res_valid && phase_reg != nfcrp_pkg::PH_DATA) begin
                res_item.kind = 1'b1;
                res_item.last = 1'b1;
                phase_next    = nfcrp_pkg::PH_IDLE;
                idle_next     = '0;
            end
        end
    end

    // Input register: hold the request until it is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_item_reg <= res_item;
        end
    end

    // Configuration registers; other indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= nfcrp_pkg::CAPACITY_RESET;
            timeout_reg  <= nfcrp_pkg::TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == nfcrp_pkg::REG_BUFFER_CAPACITY) begin
                capacity_reg <= cfg_data[7:0];
            end else if (cfg_index == nfcrp_pkg::REG_TIMEOUT_TICKS) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= nfcrp_pkg::PH_IDLE;
            expected_reg <= '0;
            length_reg   <= '0;
            left_reg     <= '0;
            paylen_reg   <= '0;
            sum_reg      <= '0;
            idle_reg     <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            length_reg   <= length_next;
            left_reg     <= left_next;
            paylen_reg   <= paylen_next;
            sum_reg      <= sum_next;
            idle_reg     <= idle_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A pending payload byte leaves the parser inside the payload or at its checksum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_item_reg.kind) |->
            (phase_reg == nfcrp_pkg::PH_DATA || phase_reg == nfcrp_pkg::PH_DCS))
        else $error("data result pending outside payload");

    // A pending status result means the frame is closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_item_reg.kind) |-> (phase_reg == nfcrp_pkg::PH_IDLE))
        else $error("status result pending while frame still open");

    // An arm request restarts the preamble search and gives no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.op == nfcrp_pkg::OP_ARM) |=>
            (phase_reg == nfcrp_pkg::PH_PRE0 && !out_valid_reg))
        else $error("arm did not restart frame");

    // Status results always carry last; data results never do
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_item_reg.last == out_item_reg.kind))
        else $error("last flag does not match result kind");
`endif

endmodule
`default_nettype wire
